// ===== rtl/pcwrl_pkg.sv =====
package pcwrl_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

  localparam logic [15:0] RESET_REQUEST_LIMIT  = 16'd10;
  localparam logic [15:0] RESET_WINDOW_SECONDS = 16'd60;
  localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic limited;
    logic table_full;
  } out_word_t;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] last_time;
  } slot_entry_t;

endpackage

// ===== rtl/pcwrl_ram.sv =====
module pcwrl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/per_client_window_rate_limiter_unit.sv =====
// Channel  Ports                          Word
// in       in_valid, in_ready, in_data    in_word_t  (client_addr, now_seconds)
// out      out_valid, out_ready, out_data out_word_t (limited, table_full)
// cfg      cfg_we, cfg_index, cfg_wdata   16-bit register write, no wait
//
// Each word passes through S_IDLE (accept), S_LOOK (tag compare with slot RAM read), S_CALC (update and write back).
// The slot RAM read-modify-write sets the rate; one word in flight at a time.
// rst_n clears the valid bits and loads the register defaults; tags and RAM are not cleared.
// A pending result in the output register does not block acceptance; the update stage
// holds only while a previous result waits.
module per_client_window_rate_limiter_unit
  import pcwrl_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = $bits(slot_entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [31:0]            tag_r [TABLE_DEPTH];
  logic [15:0]            limit_r, window_r;
  in_word_t               req_r;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic                   new_r, new_nxt;
  logic                   full_r, full_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   hit, has_free;
  logic [IDX_W-1:0]       hit_idx, free_idx;
  logic                   tag_we;

  logic                   ram_we, ram_re;
  slot_entry_t            ram_wdata, ram_rdata;
  slot_entry_t            cur;
  logic [31:0]            elapsed;
  logic [15:0]            count_inc;
  logic                   restart;
  logic                   out_free;

  pcwrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (valid_r[k] && tag_r[k] == req_r.client_addr) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
      if (!valid_r[k]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    cur       = new_r ? slot_entry_t'('0) : ram_rdata;
    elapsed   = req_r.now_seconds - cur.last_time;
    restart   = elapsed >= {16'd0, window_r};
    count_inc = (cur.count < COUNT_MAX) ? cur.count + 16'd1 : cur.count;
    if (restart) begin
      ram_wdata.count     = 16'd1;
      ram_wdata.last_time = req_r.now_seconds;
    end else begin
      ram_wdata.count     = count_inc;
      ram_wdata.last_time = cur.last_time;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    slot_nxt      = slot_r;
    new_nxt       = new_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tag_we        = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_CALC;
        full_nxt  = 1'b0;
        new_nxt   = 1'b0;
        if (hit) begin
          ram_re   = 1'b1;
          slot_nxt = hit_idx;
        end else if (has_free) begin
          tag_we              = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          slot_nxt            = free_idx;
          new_nxt             = 1'b1;
        end else begin
          full_nxt = 1'b1;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (full_r) begin
            out_data_nxt.limited    = 1'b1;
            out_data_nxt.table_full = 1'b1;
          end else begin
            ram_we                  = 1'b1;
            out_data_nxt.limited    = !restart && (count_inc > limit_r);
            out_data_nxt.table_full = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= RESET_REQUEST_LIMIT;
      window_r    <= RESET_WINDOW_SECONDS;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_REQUEST_LIMIT:  limit_r  <= cfg_wdata;
          REG_WINDOW_SECONDS: window_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (tag_we) begin
      tag_r[free_idx] <= req_r.client_addr;
    end
    slot_r     <= slot_nxt;
    new_r      <= new_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/rate_limit_checker.sv =====
module rate_limit_checker
  import pcwrl_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  logic [15:0] limit_s;
  logic [15:0] window_s;
  logic        slot_used  [TABLE_DEPTH];
  logic [31:0] slot_addr  [TABLE_DEPTH];
  slot_entry_t slot_state [TABLE_DEPTH];
  out_word_t   verdict_q  [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic out_word_t judge_request(input in_word_t w);
    out_word_t   r;
    int          hit;
    logic [31:0] elapsed;
    hit = -1;
    r   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (hit < 0 && slot_used[k] && slot_addr[k] == w.client_addr) hit = k;
    end
    if (hit < 0) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (hit < 0 && !slot_used[k]) begin
          hit                    = k;
          slot_used[k]           = 1'b1;
          slot_addr[k]           = w.client_addr;
          slot_state[k].count     = 16'd0;
          slot_state[k].last_time = 32'd0;
        end
      end
    end
    if (hit < 0) begin
      r.limited    = 1'b1;
      r.table_full = 1'b1;
      return r;
    end
    elapsed = w.now_seconds - slot_state[hit].last_time;
    if (elapsed >= {16'd0, window_s}) begin
      slot_state[hit].count     = 16'd1;
      slot_state[hit].last_time = w.now_seconds;
    end else begin
      if (slot_state[hit].count != COUNT_MAX) slot_state[hit].count++;
      r.limited = (slot_state[hit].count > limit_s);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      limit_s  = RESET_REQUEST_LIMIT;
      window_s = RESET_WINDOW_SECONDS;
      for (int k = 0; k < TABLE_DEPTH; k++) slot_used[k] = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REQUEST_LIMIT:  limit_s  = cfg_wdata[15:0];
          REG_WINDOW_SECONDS: window_s = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result word, actual %b", $time, out_data);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.limited !== want.limited) begin
            $display("%0t: limited expected %b, actual %b", $time, want.limited,
                     out_data.limited);
            fail_count++;
          end
          if (out_data.table_full !== want.table_full) begin
            $display("%0t: table_full expected %b, actual %b", $time, want.table_full,
                     out_data.table_full);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) verdict_q.push_back(judge_request(in_data));
    end
    pending = verdict_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import pcwrl_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 70;
  localparam int SAT_WORDS      = 8;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_REQUEST_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          fail_count;
  int          pending;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  bit          hold_req  = 1'b0;
  int          quiet     = 0;
  logic [31:0] clock_s   = 32'd0;
  logic [31:0] pool [16];

  int ph_limit [PHASES] = '{3, 0, 65534, 2, 5, 65535};
  int ph_win   [PHASES] = '{20, 1, 65535, 7, 100, 3};
  int ph_idle  [PHASES] = '{0, 48, 0, 23, 0, 48};
  int ph_stall [PHASES] = '{0, 0, 48, 23, 0, 48};

  per_client_window_rate_limiter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  rate_limit_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [31:0] addr, input logic [31:0] now);
    in_word_t w;
    w.client_addr = addr;
    w.now_seconds = now;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pace();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] limit, input logic [15:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REQUEST_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= REG_WINDOW_SECONDS;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(input int win);
    int          pick;
    logic [31:0] addr;
    pick = $urandom_range(99);
    if (pick < 88) addr = pool[4'($urandom_range(15))];
    else addr = $urandom;
    pick = $urandom_range(99);
    if (pick < 65) clock_s = clock_s + $urandom_range(win / 4 + 1, 0);
    else if (pick < 80) clock_s = clock_s + win - 1 + $urandom_range(2, 0);
    else if (pick < 90) clock_s = $urandom;
    else clock_s = 32'hFFFF_FFFF - $urandom_range(win / 2, 0);
    send_word(addr, clock_s);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) pool[i] = ($urandom & 32'hFFFF_FFF0) | i;
    pool[0]  = 32'h0000_0000;
    pool[15] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // claim every slot at the reset settings, the first few inside the window
    for (int i = 0; i < 16; i++) send_word(pool[i], i * 8);
    send_word($urandom | 32'h0000_0010, 32'd200);
    send_word(32'hFFFF_FFF7, 32'hFFFF_FFFF);
    // exact window boundary
    send_word(pool[8], 32'd123);
    send_word(pool[8], 32'd124);
    // elapsed time across the wrap of now_seconds
    send_word(pool[9], 32'hFFFF_FFF0);
    send_word(pool[9], 32'd5);
    send_word(pool[9], 32'd44);
    drain();

    load_regs(16'd0, 16'd0);
    send_word(pool[2], 32'd500);
    send_word(pool[2], 32'd500);
    drain();

    // hammer one client under a high limit, then lift the limit to the top
    load_regs(16'd65534, 16'd65535);
    for (int n = 0; n < SAT_WORDS; n++) send_word(pool[3], 32'h0010_0000);
    drain();
    load_regs(16'd65535, 16'd65535);
    send_word(pool[3], 32'h0010_0000);
    send_word(pool[3], 32'h0010_0001);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      load_regs(16'(ph_limit[p]), 16'(ph_win[p]));
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 3 && n == PHASE_WORDS / 2) drain();
        pace();
        send_random(ph_win[p]);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
